### rtl/hms_pkg.sv
// shared widths, constants and types for the hms clock
`default_nettype none

package hms_pkg;

  localparam int unsigned MS_W    = 32;
  localparam int unsigned TOTAL_W = 23;
  localparam int unsigned DH_W    = 11;
  localparam int unsigned REM_W   = 12;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned PAD_W   = OUT_DATA_W - HOUR_W - MIN_W - SEC_W;

  // reciprocals, rounded down, with a one-step upward correction after use
  localparam logic [22:0] RECIP_1000 = 23'd4294967;
  localparam logic [20:0] RECIP_3600 = 21'd1193046;
  localparam logic [10:0] RECIP_60   = 11'd1092;
  localparam logic [11:0] RECIP_24   = 12'd2730;

  localparam logic [10:0] MS_PER_SEC    = 11'd1000;
  localparam logic [12:0] SEC_PER_HOUR  = 13'd3600;
  localparam logic [6:0]  SEC_PER_MIN   = 7'd60;
  localparam logic [5:0]  HOURS_PER_DAY = 6'd24;

  localparam logic [TOTAL_W-1:0] MAX_TOTAL_SECS = 23'd4294967;
  localparam logic [DH_W-1:0]    MAX_DH         = 11'd1193;

  typedef struct packed {
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [SEC_W-1:0]  seconds;
  } hms_t;

endpackage

`default_nettype wire

### rtl/hms_split.sv
// splits a count of whole seconds into hours mod 24, minutes and seconds
`default_nettype none

module hms_split import hms_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [TOTAL_W-1:0] secs,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hms_t                    delta
);

  logic              a_vld_r;
  logic [DH_W-1:0]   dh_r;
  logic [REM_W-1:0]  rem_r;
  logic              b_vld_r;
  hms_t              delta_r;

  logic              a_ready;
  logic              b_ready;

  logic [43:0]       prod_a;
  logic [DH_W-1:0]   hq_est;
  logic [12:0]       hq_mul;
  logic [12:0]       rem_est;
  logic [12:0]       rem_adj;
  logic              fix_a;
  logic [DH_W-1:0]   dh_nxt;
  logic [REM_W-1:0]  rem_nxt;

  logic [22:0]       prod_m;
  logic [MIN_W-1:0]  mq_est;
  logic [6:0]        mq_mul;
  logic [6:0]        s_est;
  logic [6:0]        s_adj;
  logic              fix_m;

  logic [22:0]       prod_h;
  logic [6:0]        dq_est;
  logic [5:0]        dq_mul;
  logic [5:0]        h_est;
  logic [5:0]        h_adj;
  logic              fix_h;
  hms_t              delta_nxt;

  assign b_ready  = !b_vld_r || out_ready;
  assign a_ready  = !a_vld_r || b_ready;
  assign in_ready = a_ready;

  // whole hours and leftover seconds
  always_comb begin
    prod_a  = {21'b0, secs} * {23'b0, RECIP_3600};
    hq_est  = prod_a[42:32];
    hq_mul  = {2'b0, hq_est} * SEC_PER_HOUR;
    rem_est = secs[12:0] - hq_mul;
    fix_a   = rem_est >= SEC_PER_HOUR;
    rem_adj = rem_est - SEC_PER_HOUR;
    dh_nxt  = hq_est + {{(DH_W-1){1'b0}}, fix_a};
    rem_nxt = fix_a ? rem_adj[REM_W-1:0] : rem_est[REM_W-1:0];
  end

  // minutes, seconds and hours folded into one day
  always_comb begin
    prod_m = {11'b0, rem_r} * {12'b0, RECIP_60};
    mq_est = prod_m[21:16];
    mq_mul = {1'b0, mq_est} * SEC_PER_MIN;
    s_est  = rem_r[6:0] - mq_mul;
    fix_m  = s_est >= SEC_PER_MIN;
    s_adj  = s_est - SEC_PER_MIN;

    prod_h = {12'b0, dh_r} * {11'b0, RECIP_24};
    dq_est = prod_h[22:16];
    dq_mul = dq_est[5:0] * HOURS_PER_DAY;
    h_est  = dh_r[5:0] - dq_mul;
    fix_h  = h_est >= HOURS_PER_DAY;
    h_adj  = h_est - HOURS_PER_DAY;

    delta_nxt.hours   = fix_h ? h_adj[HOUR_W-1:0] : h_est[HOUR_W-1:0];
    delta_nxt.minutes = mq_est + {{(MIN_W-1){1'b0}}, fix_m};
    delta_nxt.seconds = fix_m ? s_adj[SEC_W-1:0] : s_est[SEC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_vld_r <= in_valid;
      end
      if (b_ready) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      dh_r  <= dh_nxt;
      rem_r <= rem_nxt;
    end
    if (b_ready && a_vld_r) begin
      delta_r <= delta_nxt;
    end
  end

  assign out_valid = b_vld_r;
  assign delta     = delta_r;

  a_split_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r |-> (rem_r < 12'd3600) && (dh_r <= MAX_DH))
    else $error("hour split out of range");

  a_split_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
    b_vld_r |-> (delta_r.hours < 5'd24) && (delta_r.minutes < 6'd60) &&
                (delta_r.seconds < 6'd60))
    else $error("delta fields out of range");

endmodule

`default_nettype wire

### rtl/hms_acc.sv
// time of day register with second and minute carries and day wrap
`default_nettype none

module hms_acc import hms_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire hms_t delta,
  output logic      out_valid,
  input  wire logic out_ready,
  output hms_t      tod
);

  logic              out_vld_r;
  logic [HOUR_W-1:0] hour_r;
  logic [MIN_W-1:0]  minute_r;
  logic [SEC_W-1:0]  second_r;
  logic [HOUR_W-1:0] hour_nxt;
  logic [MIN_W-1:0]  minute_nxt;
  logic [SEC_W-1:0]  second_nxt;

  logic              load;
  logic [6:0]        sec_sum;
  logic [6:0]        sec_adj;
  logic              c_sec;
  logic [6:0]        min_sum;
  logic [6:0]        min_adj;
  logic              c_min;
  logic [5:0]        hr_sum;
  logic [5:0]        hr_adj;

  assign in_ready = !out_vld_r || out_ready;
  assign load     = in_valid && in_ready;

  always_comb begin
    sec_sum    = {1'b0, second_r} + {1'b0, delta.seconds};
    c_sec      = sec_sum >= SEC_PER_MIN;
    sec_adj    = sec_sum - SEC_PER_MIN;
    second_nxt = c_sec ? sec_adj[SEC_W-1:0] : sec_sum[SEC_W-1:0];

    min_sum    = {1'b0, minute_r} + {1'b0, delta.minutes} + {6'b0, c_sec};
    c_min      = min_sum >= SEC_PER_MIN;
    min_adj    = min_sum - SEC_PER_MIN;
    minute_nxt = c_min ? min_adj[MIN_W-1:0] : min_sum[MIN_W-1:0];

    hr_sum     = {1'b0, hour_r} + {1'b0, delta.hours} + {5'b0, c_min};
    hr_adj     = hr_sum - HOURS_PER_DAY;
    hour_nxt   = (hr_sum >= HOURS_PER_DAY) ? hr_adj[HOUR_W-1:0] : hr_sum[HOUR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      hour_r    <= '0;
      minute_r  <= '0;
      second_r  <= '0;
    end else begin
      if (in_ready) begin
        out_vld_r <= in_valid;
      end
      if (load) begin
        hour_r   <= hour_nxt;
        minute_r <= minute_nxt;
        second_r <= second_nxt;
      end
    end
  end

  assign out_valid   = out_vld_r;
  assign tod.hours   = hour_r;
  assign tod.minutes = minute_r;
  assign tod.seconds = second_r;

  a_acc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (hour_r < 5'd24) && (minute_r < 6'd60) && (second_r < 6'd60))
    else $error("time of day out of range");

  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(hour_r) && $stable(minute_r) && $stable(second_r))
    else $error("time of day changed without a word");

endmodule

`default_nettype wire

### rtl/hms_clock_from_ms_timestamp.sv
// top level: timestamp register, anchor and seconds stage, split and accumulate
// an accepted word passes the timestamp, seconds, split and time of day registers
// throughput: one word per cycle while out_tready holds high; the anchor loop (subtract,
// reciprocal multiply, correction) closes within a single stage, the other stages are plain pipeline
// reset: synchronous on rst_n low, clears the anchor, the time of day and all valid flags
`default_nettype none

module hms_clock_from_ms_timestamp import hms_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [MS_W-1:0]       in_tdata,   // now_ms [31:0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // hour_now [4:0], minute_now [10:5],
                                                 // second_now [16:11], zero [23:17]
);

  logic               now_vld_r;
  logic [MS_W-1:0]    now_r;
  logic               sec_vld_r;
  logic [TOTAL_W-1:0] sec_r;
  logic [TOTAL_W-1:0] sec_nxt;
  logic [MS_W-1:0]    anchor_r;
  logic [MS_W-1:0]    anchor_nxt;

  logic               s1_ready;
  logic               s2_ready;
  logic               split_ready;
  logic               dlt_vld;
  logic               acc_ready;
  hms_t               dlt;
  hms_t               tod;

  logic [MS_W-1:0]    diff;
  logic [54:0]        prod;
  logic [TOTAL_W-1:0] q_est;
  logic [10:0]        q_mul;
  logic [10:0]        r_est;
  logic [10:0]        r_adj;
  logic               fix_r;
  logic [9:0]         rest;

  assign s2_ready  = !sec_vld_r || split_ready;
  assign s1_ready  = !now_vld_r || s2_ready;
  assign in_tready = s1_ready;

  // whole seconds since the anchor and the millisecond leftover
  always_comb begin
    diff       = now_r - anchor_r;
    prod       = {23'b0, diff} * {32'b0, RECIP_1000};
    q_est      = prod[54:32];
    q_mul      = q_est[10:0] * MS_PER_SEC;
    r_est      = diff[10:0] - q_mul;
    fix_r      = r_est >= MS_PER_SEC;
    r_adj      = r_est - MS_PER_SEC;
    rest       = fix_r ? r_adj[9:0] : r_est[9:0];
    sec_nxt    = q_est + {{(TOTAL_W-1){1'b0}}, fix_r};
    anchor_nxt = now_r - {22'b0, rest};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_vld_r <= 1'b0;
      sec_vld_r <= 1'b0;
      anchor_r  <= '0;
    end else begin
      if (s1_ready) begin
        now_vld_r <= in_tvalid;
      end
      if (s2_ready) begin
        sec_vld_r <= now_vld_r;
      end
      if (now_vld_r && s2_ready) begin
        anchor_r <= anchor_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_tvalid) begin
      now_r <= in_tdata;
    end
    if (now_vld_r && s2_ready) begin
      sec_r <= sec_nxt;
    end
  end

  hms_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sec_vld_r),
    .in_ready  (split_ready),
    .secs      (sec_r),
    .out_valid (dlt_vld),
    .out_ready (acc_ready),
    .delta     (dlt)
  );

  hms_acc u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dlt_vld),
    .in_ready  (acc_ready),
    .delta     (dlt),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .tod       (tod)
  );

  assign out_tdata = {{PAD_W{1'b0}}, tod.seconds, tod.minutes, tod.hours};

  a_anchor_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(now_vld_r && s2_ready) |=> $stable(anchor_r))
    else $error("anchor moved without a word");

  a_secs_range: assert property (@(posedge clk) disable iff (!rst_n)
    sec_vld_r |-> sec_r <= MAX_TOTAL_SECS)
    else $error("whole second count out of range");

endmodule

`default_nettype wire
